/* src/assert_macros.svh */
// Assertion macros used by the checker module of the color counter.
// No dependencies; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition on the same edge as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition on the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dcc_pkg.sv */
// Package of the distinct color counter: sizes, entry layout and request/result types.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package dcc_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int COUNT_WIDTH = 16;
	localparam int COLOR_W     = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       clear_first;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]       slot;
		logic [COUNT_WIDTH-1:0] occurrences;
		logic                   is_new;
		logic                   table_full;
	} rsp_t;

	typedef struct packed {
		logic [COLOR_W-1:0]     color;
		logic [COUNT_WIDTH-1:0] count;
	} entry_t;

	typedef struct packed {
		logic                   hit;
		logic [COUNT_WIDTH-1:0] count;
	} match_t;

endpackage

/* src/dcc_table.sv */
// Color/count table storage: one write port and one read port with registered data.
// Depends on dcc_pkg for the entry layout and the table depth.
`timescale 1ns / 1ps

module dcc_table (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [dcc_pkg::IDX_W-1:0] wr_addr,
	input  dcc_pkg::entry_t           wr_data,
	input  logic                      rd_en,
	input  logic [dcc_pkg::IDX_W-1:0] rd_addr,
	output dcc_pkg::entry_t           rd_data
);

	dcc_pkg::entry_t mem_q [dcc_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/dcc_match.sv */
// Shared compare unit: checks one stored entry against the search color and
// forms its saturating incremented count. Depends on dcc_pkg.
`timescale 1ns / 1ps

module dcc_match (
	input  logic [dcc_pkg::COLOR_W-1:0] color,
	input  dcc_pkg::entry_t             entry,
	output dcc_pkg::match_t             result
);

	logic sat;

	assign sat = &entry.count;

	always_comb begin
		result.hit   = (entry.color == color);
		result.count = sat ? entry.count
		                   : entry.count + dcc_pkg::COUNT_WIDTH'(1);
	end

endmodule

/* src/distinct_color_counter.sv */
// Top level of the distinct color counter: search sequencer, fill level and result register.
// Depends on dcc_pkg, dcc_table and dcc_match.
//
//   port     dir  width            role
//   start    in   1                request strobe, taken when busy is low
//   busy     out  1                high while a request is being worked on
//   req      in   dcc_pkg::req_t   color and clear flag of the request
//   done     out  1                one-cycle strobe of a result
//   rsp      out  dcc_pkg::rsp_t   slot, count and flags of the result
//
// The table is read one entry per cycle through its single read port, with the
// compare in the cycle after the read. busy is low in the cycle done shows. A match
// ends the search and strobes done; a new color or a full table is answered from the
// insert state after the last entry misses, or straight from idle if the table is empty.
// Reset clears the fill level and the sequencer; table contents are left as they are.
`timescale 1ns / 1ps

module distinct_color_counter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dcc_pkg::req_t   req,
	output logic            done,
	output dcc_pkg::rsp_t   rsp
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_INSERT = 2'd2;

	logic [1:0]                    state_q;
	logic [dcc_pkg::COLOR_W-1:0]   color_q;
	logic [dcc_pkg::FILL_W-1:0]    fill_q;
	logic [dcc_pkg::FILL_W-1:0]    fill_next;
	logic [dcc_pkg::IDX_W-1:0]     fill_last;
	logic [dcc_pkg::IDX_W-1:0]     idx_q;
	logic                          issue_q;
	logic                          cmp_vld_s1;
	logic [dcc_pkg::IDX_W-1:0]     cmp_addr_s1;
	logic                          done_q;
	dcc_pkg::rsp_t                 rsp_q;

	logic                          accept;
	logic                          is_full;
	logic                          hit_now;
	logic                          last_miss;
	logic                          wr_en;
	logic [dcc_pkg::IDX_W-1:0]     wr_addr;
	dcc_pkg::entry_t               wr_data;
	logic                          rd_en;
	dcc_pkg::entry_t               rd_data;
	dcc_pkg::match_t               match;

	assign accept    = start && (state_q == ST_IDLE);
	assign fill_next = req.clear_first ? '0 : fill_q;
	assign fill_last = dcc_pkg::IDX_W'(fill_q - dcc_pkg::FILL_W'(1));
	assign is_full   = (fill_q == dcc_pkg::FILL_W'(dcc_pkg::TABLE_DEPTH));

	assign rd_en     = (state_q == ST_SEARCH) && issue_q;
	assign hit_now   = (state_q == ST_SEARCH) && cmp_vld_s1 && match.hit;
	assign last_miss = (state_q == ST_SEARCH) && cmp_vld_s1 && !match.hit
	                   && (cmp_addr_s1 == fill_last);

	dcc_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	dcc_match u_match (
		.color  (color_q),
		.entry  (rd_data),
		.result (match)
	);

	// A match rewrites the entry with its new count; a miss appends the color unless the table is full.
	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = cmp_addr_s1;
		wr_data.color = color_q;
		wr_data.count = match.count;
		if (hit_now) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_INSERT) && !is_full) begin
			wr_en         = 1'b1;
			wr_addr       = fill_q[dcc_pkg::IDX_W-1:0];
			wr_data.count = dcc_pkg::COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			issue_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q  <= fill_next;
						issue_q <= (fill_next != '0);
						state_q <= (fill_next == '0) ? ST_INSERT : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (issue_q && (idx_q == fill_last)) begin
						issue_q <= 1'b0;
					end
					cmp_vld_s1 <= issue_q;
					if (hit_now) begin
						done_q     <= 1'b1;
						issue_q    <= 1'b0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_IDLE;
					end else if (last_miss) begin
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (!is_full) begin
						fill_q <= fill_q + dcc_pkg::FILL_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			color_q <= {req.red, req.green, req.blue, req.alpha};
			idx_q   <= '0;
		end else if (rd_en) begin
			idx_q <= idx_q + dcc_pkg::IDX_W'(1);
		end
		cmp_addr_s1 <= idx_q;
		if (hit_now) begin
			rsp_q.slot        <= cmp_addr_s1;
			rsp_q.occurrences <= match.count;
			rsp_q.is_new      <= 1'b0;
			rsp_q.table_full  <= 1'b0;
		end else if (state_q == ST_INSERT) begin
			if (is_full) begin
				rsp_q.slot        <= '0;
				rsp_q.occurrences <= '0;
				rsp_q.is_new      <= 1'b0;
				rsp_q.table_full  <= 1'b1;
			end else begin
				rsp_q.slot        <= fill_q[dcc_pkg::IDX_W-1:0];
				rsp_q.occurrences <= dcc_pkg::COUNT_WIDTH'(1);
				rsp_q.is_new      <= 1'b1;
				rsp_q.table_full  <= 1'b0;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* src/dcc_checker.sv */
// Port-level checker of the distinct color counter, bound to the top level.
// Depends on dcc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input dcc_pkg::rsp_t rsp
);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted request did not raise busy")
	`ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result shown while busy")
	`ASSERT_NOW(a_busy_end, clk, arst_n, $fell(busy), done, "busy fell without a result")
	`ASSERT_NOW(a_flags, clk, arst_n, done, !(rsp.is_new && rsp.table_full), "new and full together")
	`ASSERT_NOW(a_full_zero, clk, arst_n, done && rsp.table_full, (rsp.slot == '0) && (rsp.occurrences == '0), "full result not zero")

endmodule

bind distinct_color_counter dcc_checker u_dcc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

/* tb/tb_distinct_color_counter.sv */
`timescale 1ns / 1ps
// Self-checking bench for distinct_color_counter: directed colors, a run of hits on one color
// and random palette/fill episodes, checked against the table model or typed-in results.
// Depends on dcc_pkg and the distinct_color_counter RTL.

module tb_distinct_color_counter;

	localparam int RANDOM_ITEMS = 780;
	localparam int QUIET_TAIL   = 120;
	localparam int SAT_ITEMS    = 40;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = dcc_pkg::TABLE_DEPTH + 12;
	localparam int REPORT_MAX   = 10;
	localparam int DIR_ROWS     = 21;
	localparam logic [dcc_pkg::COUNT_WIDTH-1:0] COUNT_TOP = '1;

	typedef struct {
		logic [31:0]   color;
		bit            clr;
		bit            typed;
		dcc_pkg::rsp_t want;
	} dir_row_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	dcc_pkg::req_t  req = '0;
	logic           busy;
	logic           done;
	dcc_pkg::rsp_t  rsp;

	// Bench copy of the color table.
	logic [31:0]                     seen_color [dcc_pkg::TABLE_DEPTH];
	logic [dcc_pkg::COUNT_WIDTH-1:0] seen_count [dcc_pkg::TABLE_DEPTH];
	int                              seen_fill = 0;

	dcc_pkg::rsp_t awaited[$];
	int            mismatches = 0;
	int            stall_cycles = 0;
	bit            idle_ok = 1'b0;

	// Rows with an expected result are readable by eye; the rest go through the model.
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{32'h0000_0000, 1'b0, 1'b1, '{7'd0, 16'd1, 1'b1, 1'b0}},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, '{7'd1, 16'd1, 1'b1, 1'b0}},
		'{32'h0000_0000, 1'b0, 1'b1, '{7'd0, 16'd2, 1'b0, 1'b0}},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, '{7'd1, 16'd2, 1'b0, 1'b0}},
		'{32'hFF00_0000, 1'b0, 1'b1, '{7'd2, 16'd1, 1'b1, 1'b0}},
		'{32'h00FF_0000, 1'b0, 1'b0, '0},
		'{32'h0000_FF00, 1'b0, 1'b0, '0},
		'{32'h0000_00FF, 1'b0, 1'b0, '0},
		'{32'h0000_00FF, 1'b0, 1'b1, '{7'd5, 16'd2, 1'b0, 1'b0}},
		'{32'hA55A_C33C, 1'b0, 1'b0, '0},
		'{32'h5AA5_3CC3, 1'b0, 1'b0, '0},
		'{32'hA55A_C33C, 1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, '{7'd0, 16'd1, 1'b1, 1'b0}},
		'{32'h0000_0000, 1'b0, 1'b1, '{7'd1, 16'd1, 1'b1, 1'b0}},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
		'{32'h0000_0000, 1'b1, 1'b1, '{7'd0, 16'd1, 1'b1, 1'b0}},
		'{32'h0000_0000, 1'b1, 1'b1, '{7'd0, 16'd1, 1'b1, 1'b0}},
		'{32'h0000_0000, 1'b0, 1'b0, '0},
		'{32'h1234_5678, 1'b0, 1'b0, '0},
		'{32'h1234_5679, 1'b0, 1'b0, '0},
		'{32'h9234_5678, 1'b0, 1'b0, '0}
	};

	distinct_color_counter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	function automatic dcc_pkg::rsp_t tally_color(input logic [31:0] color, input bit clr);
		dcc_pkg::rsp_t t;
		int            k;
		t = '0;
		if (clr)
			seen_fill = 0;
		for (k = 0; k < seen_fill; k++) begin
			if (seen_color[k] == color) begin
				if (seen_count[k] != COUNT_TOP)
					seen_count[k] = seen_count[k] + dcc_pkg::COUNT_WIDTH'(1);
				t.slot = k[dcc_pkg::IDX_W-1:0];
				t.occurrences = seen_count[k];
				return t;
			end
		end
		if (seen_fill >= dcc_pkg::TABLE_DEPTH) begin
			t.table_full = 1'b1;
			return t;
		end
		seen_color[seen_fill] = color;
		seen_count[seen_fill] = dcc_pkg::COUNT_WIDTH'(1);
		t.slot = seen_fill[dcc_pkg::IDX_W-1:0];
		t.occurrences = dcc_pkg::COUNT_WIDTH'(1);
		t.is_new = 1'b1;
		seen_fill++;
		return t;
	endfunction

	// Returns in the time step of the accepting edge with start still high.
	task automatic issue(input logic [31:0] color, input bit clr, input bit typed,
			input dcc_pkg::rsp_t want);
		dcc_pkg::rsp_t predicted;
		int            gap;
		gap = (idle_ok && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= dcc_pkg::req_t'({color, clr});
		do @(posedge clk); while (busy !== 1'b0);
		predicted = tally_color(color, clr);
		awaited.push_back(typed ? want : predicted);
	endtask

	always @(posedge clk) begin
		dcc_pkg::rsp_t want;
		if (arst_n && done !== 1'b0) begin
			if (awaited.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: unexpected result slot %0d occ %0d new %b full %b",
						$time, rsp.slot, rsp.occurrences, rsp.is_new, rsp.table_full);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				if (rsp.slot !== want.slot || rsp.occurrences !== want.occurrences ||
						rsp.is_new !== want.is_new || rsp.table_full !== want.table_full) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: want slot %0d occ %0d new %b full %b, got %0d %0d %b %b",
							$time, want.slot, want.occurrences, want.is_new, want.table_full,
							rsp.slot, rsp.occurrences, rsp.is_new, rsp.table_full);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("tb_distinct_color_counter: done, errors");
		$finish;
	end

	initial begin
		int          k;
		int          sent;
		int          pick;
		int          len;
		int          pal_n;
		logic [31:0] pal [16];
		logic [31:0] c;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_ok = 1'b1;
		for (k = 0; k < DIR_ROWS; k++)
			issue(directed_rows[k].color, directed_rows[k].clr, directed_rows[k].typed,
				directed_rows[k].want);

		// Hammer one color in slot 0 with a long run of back-to-back hits.
		idle_ok = 1'b0;
		c = $urandom();
		issue(c, 1'b1, 1'b0, '0);
		for (k = 1; k < SAT_ITEMS; k++)
			issue(c, 1'b0, 1'b0, '0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_ok = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			pick = (sent == 0) ? 0 : $urandom_range(0, 9);
			if (pick < 3) begin
				// Let the block drain, then fill the table to the brim and probe it.
				start <= 1'b0;
				while (awaited.size() != 0) @(posedge clk);
				issue($urandom(), 1'b1, 1'b0, '0);
				sent++;
				while (seen_fill < dcc_pkg::TABLE_DEPTH) begin
					issue($urandom(), 1'b0, 1'b0, '0);
					sent++;
				end
				for (k = 0; k < 12; k++) begin
					if (k[0])
						c = seen_color[$urandom_range(0, dcc_pkg::TABLE_DEPTH - 1)];
					else
						c = $urandom();
					issue(c, 1'b0, 1'b0, '0);
					sent++;
				end
			end else if (pick < 9) begin
				pal_n = $urandom_range(1, 16);
				for (k = 0; k < pal_n; k++)
					pal[k] = $urandom();
				len = $urandom_range(10, 40);
				for (k = 0; k < len; k++) begin
					c = ($urandom_range(0, 6) == 0) ? $urandom()
						: pal[$urandom_range(0, pal_n - 1)];
					issue(c, ((k == 0) && ($urandom_range(0, 1) == 1)) ||
						($urandom_range(0, 40) == 0), 1'b0, '0);
					sent++;
				end
			end else begin
				for (k = 0; k < 5; k++) begin
					issue($urandom(), 1'($urandom_range(0, 1)), 1'b0, '0);
					sent++;
				end
			end
		end

		start <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_distinct_color_counter: done, clean");
		else
			$display("tb_distinct_color_counter: done, errors");
		$finish;
	end

endmodule
